// File: rtl/sorted_coordinate_table_search_core_macros.svh
// Assertion macros for the sorted coordinate table search core.
// Depends on nothing; included by the modules that assert.
`ifndef SORTED_COORDINATE_TABLE_SEARCH_CORE_MACROS_SVH
`define SORTED_COORDINATE_TABLE_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define SCTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/scts_pkg.sv
// Package for the sorted coordinate table search core: payload types and codes.
// Depends on nothing.
`timescale 1ns / 1ps

package scts_pkg;

   localparam int TableDepthDefault = 1024;
   localparam int CoordWidthDefault = 16;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_SORT   = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;
   localparam logic [1:0] CMD_SPARE  = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_UNSORTED  = 3'd4;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  entry_index;
      logic [10:0] entry_count;
   } rsp_type;

endpackage

// File: rtl/sorted_coordinate_table_search_core.sv
// Sorted coordinate table search core: key table memory, append, stable
// insertion sort and lower-bound find under one sequencer.
// Depends on scts_pkg and sorted_coordinate_table_search_core_macros.svh.
//
//   channel   ports                     transfer
//   --------  ------------------------  ---------------------------------
//   request   start, busy, req_item     edge with start high, busy low
//   result    rsp_strobe, rsp_item      edge ending the one strobe cycle
//
// Append, out-of-range, not-sorted, unused commands and sorts of at most one
// key: result in the cycle after the transfer. Find: S_PROBE and S_CMPF per
// probe of the single memory read port. Sort: insertion sort on one read and
// one write port: S_RDCUR, S_WAITCUR, then S_RDPREV and S_CMP per compare.
// Synchronous reset empties the table; no clearing pass. Results cannot be
// stalled; busy holds off requests while a sort or find runs.
`timescale 1ns / 1ps
`include "sorted_coordinate_table_search_core_macros.svh"

module sorted_coordinate_table_search_core #(
   parameter int TABLE_DEPTH = scts_pkg::TableDepthDefault,
   parameter int COORD_WIDTH = scts_pkg::CoordWidthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  scts_pkg::req_type req_item,
   output logic              rsp_strobe,
   output scts_pkg::rsp_type rsp_item
);
   import scts_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CW    = COORD_WIDTH;
   localparam int KW    = 3 * CW;

   typedef enum logic [2:0] {
      S_IDLE, S_RDCUR, S_WAITCUR, S_RDPREV, S_CMP, S_PROBE, S_CMPF
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sorted_ff, sorted_in;
   logic [KW-1:0]    key_ff, key_in;
   logic [KW-1:0]    cur_ff, cur_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic             eq_ff, eq_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [KW-1:0] mem [TABLE_DEPTH];
   logic [KW-1:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [KW-1:0] mem_wdata;

   logic [KW-1:0]    req_key;
   logic             range_ok;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] i_next;
   logic [63:0]      idx_wide;
   logic [63:0]      cnt_wide;

   // sign bit flipped so an unsigned compare of {y,x,z} gives the signed order
   assign req_key = {~req_item.coord_y[CW-1], req_item.coord_y[CW-2:0],
                     ~req_item.coord_x[CW-1], req_item.coord_x[CW-2:0],
                     ~req_item.coord_z[CW-1], req_item.coord_z[CW-2:0]};

   assign range_ok =
      ((&req_item.coord_x[31:CW-1]) || !(|req_item.coord_x[31:CW-1])) &&
      ((&req_item.coord_y[31:CW-1]) || !(|req_item.coord_y[31:CW-1])) &&
      ((&req_item.coord_z[31:CW-1]) || !(|req_item.coord_z[31:CW-1]));

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];
   assign i_next  = i_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sorted_in    = sorted_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      eq_in        = eq_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = cur_ff;
      idx_wide     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in        = req_key;
               rsp_in.status = ST_OK;
               unique case (req_item.command)
                  CMD_APPEND: begin
                     if (!range_ok) begin
                        rsp_in.status = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = count_ff[AW-1:0];
                        mem_wdata    = req_key;
                        idx_wide     = 64'(count_ff);
                        count_in     = count_ff + CNT_W'(1);
                        sorted_in    = 1'b0;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_SORT: begin
                     sorted_in = 1'b1;
                     if (count_ff <= CNT_W'(1)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        i_in     = CNT_W'(1);
                        state_in = S_RDCUR;
                     end
                  end
                  CMD_FIND: begin
                     if (!range_ok) begin
                        rsp_in.status = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (!sorted_ff) begin
                        rsp_in.status = ST_UNSORTED;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        eq_in    = 1'b0;
                        state_in = S_PROBE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
               rsp_in.entry_index = idx_wide[9:0];
            end
         end
         S_RDCUR: begin
            mem_raddr = i_ff[AW-1:0];
            state_in  = S_WAITCUR;
         end
         S_WAITCUR: begin
            cur_in   = rdata_ff;
            j_in     = i_ff;
            state_in = S_RDPREV;
         end
         S_RDPREV: begin
            if (j_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = cur_ff;
               i_in      = i_next;
               state_in  = (i_next >= count_ff) ? S_IDLE : S_RDCUR;
            end else begin
               mem_raddr = AW'(j_ff - CNT_W'(1));
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[AW-1:0];
            if (cur_ff < rdata_ff) begin
               mem_wdata = rdata_ff;
               j_in      = j_ff - CNT_W'(1);
               state_in  = S_RDPREV;
            end else begin
               mem_wdata = cur_ff;
               i_in      = i_next;
               state_in  = (i_next >= count_ff) ? S_IDLE : S_RDCUR;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mem_raddr = mid[AW-1:0];
               state_in  = S_CMPF;
            end else begin
               idx_wide = eq_ff ? 64'(lo_ff) : 64'd0;
               rsp_in.status      = eq_ff ? ST_OK : ST_NOT_FOUND;
               rsp_in.entry_index = idx_wide[9:0];
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_CMPF: begin
            if (rdata_ff < key_ff) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
               eq_in = (rdata_ff == key_ff);
            end
            state_in = S_PROBE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // sort finishing from the sequencer
      if ((state_ff == S_RDPREV || state_ff == S_CMP) && state_in == S_IDLE) begin
         rsp_in.status      = ST_OK;
         rsp_in.entry_index = '0;
         rsp_valid_in       = 1'b1;
      end
      cnt_wide           = 64'(count_in);
      rsp_in.entry_count = cnt_wide[10:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sorted_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in;
      cur_ff <= cur_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      eq_ff  <= eq_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `SCTS_ASSERT_NOW(a_rsp_has_cause, clock, reset, rsp_strobe, $past(start && !busy) || $past(busy), "result without a request")
   `SCTS_ASSERT_NOW(a_busy_ends_rsp, clock, reset, $fell(busy), rsp_strobe, "sequence ended without a result")
   `SCTS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "key count past table depth")
   `SCTS_ASSERT_NEXT(a_sort_sets_flag, clock, reset, start && !busy && req_item.command == CMD_SORT, sorted_ff, "sort left table unsorted")

endmodule

// File: tb/tb.sv
// Testbench for sorted_coordinate_table_search_core: appends, sorts and finds
// grid keys, predicting each result with a local table model and scoreboard.
// Depends on scts_pkg and the core RTL.
`timescale 1ns / 1ps

class table_scoreboard;
   scts_pkg::rsp_type expected_q[$];
   logic signed [31:0] kx[1024], ky[1024], kz[1024];
   int unsigned key_count;
   bit sorted;
   int errors;
   int found_hits;

   function new();
      key_count = 0;
      sorted = 1;
      errors = 0;
      found_hits = 0;
   endfunction

   function bit in_range(logic signed [31:0] v);
      return v >= -32768 && v <= 32767;
   endfunction

   function bit key_lt(logic signed [31:0] ax, ay, az, bx, by, bz);
      if (ay != by) return ay < by;
      if (ax != bx) return ax < bx;
      return az < bz;
   endfunction

   function void note_request(scts_pkg::req_type r);
      scts_pkg::rsp_type e;
      logic signed [31:0] cx, cy, cz;
      int unsigned lo, hi, mid, j;
      bit ok;
      e = '0;
      ok = in_range(r.coord_x) && in_range(r.coord_y) && in_range(r.coord_z);
      case (r.command)
         scts_pkg::CMD_APPEND: begin
            if (!ok) e.status = scts_pkg::ST_RANGE;
            else if (key_count >= 1024) e.status = scts_pkg::ST_FULL;
            else begin
               kx[key_count] = r.coord_x;
               ky[key_count] = r.coord_y;
               kz[key_count] = r.coord_z;
               e.entry_index = key_count[9:0];
               key_count++;
               sorted = 0;
            end
         end
         scts_pkg::CMD_SORT: begin
            for (int i = 1; i < key_count; i++) begin
               cx = kx[i]; cy = ky[i]; cz = kz[i];
               j = i;
               while (j > 0 && key_lt(cx, cy, cz, kx[j-1], ky[j-1], kz[j-1])) begin
                  kx[j] = kx[j-1]; ky[j] = ky[j-1]; kz[j] = kz[j-1];
                  j--;
               end
               kx[j] = cx; ky[j] = cy; kz[j] = cz;
            end
            sorted = 1;
         end
         scts_pkg::CMD_FIND: begin
            if (!ok) e.status = scts_pkg::ST_RANGE;
            else if (!sorted) e.status = scts_pkg::ST_UNSORTED;
            else begin
               lo = 0; hi = key_count;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (key_lt(kx[mid], ky[mid], kz[mid], r.coord_x, r.coord_y, r.coord_z))
                     lo = mid + 1;
                  else hi = mid;
               end
               if (lo < key_count && kx[lo] == r.coord_x && ky[lo] == r.coord_y
                   && kz[lo] == r.coord_z) begin
                  e.entry_index = lo[9:0];
                  found_hits++;
               end else e.status = scts_pkg::ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
      e.entry_count = key_count[10:0];
      expected_q.push_back(e);
   endfunction

   task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   task check_result(scts_pkg::rsp_type got);
      scts_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         report("unexpected result, status", got.status, 0);
         return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) report("status", got.status, e.status);
      if (got.entry_index !== e.entry_index) report("entry_index", got.entry_index, e.entry_index);
      if (got.entry_count !== e.entry_count) report("entry_count", got.entry_count, e.entry_count);
   endtask
endclass

module tb;
   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic rsp_strobe;
   scts_pkg::req_type req_item = '0;
   scts_pkg::rsp_type rsp_item;
   table_scoreboard sb;
   int idle_cycles;
   int transfers;
   bit calm;
   logic signed [31:0] pool_x[16], pool_y[16], pool_z[16];

   sorted_coordinate_table_search_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   // a long insertion sort accepts no request while it runs; the watchdog counts cycles with no transfer or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000000) begin
         $display("watchdog expired");
         $display("sorted_coordinate_table_search_core: mismatch");
         $finish;
      end
   end

   task send(logic [1:0] cmd, logic signed [31:0] x, y, z);
      scts_pkg::req_type r;
      r.command = cmd; r.coord_x = x; r.coord_y = y; r.coord_z = z;
      while (!calm && $urandom_range(99) < 17) begin
         start <= 0;
         @(posedge clock);
      end
      req_item <= r;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
      transfers++;
   endtask

   task drain();
      start <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function logic signed [31:0] rnd_coord(bit wide);
      if (wide) return $urandom;
      return $signed($urandom_range(65535)) - 32768;
   endfunction

   initial begin
      int c;
      sb = new();
      idle_cycles = 0;
      transfers = 0;
      calm = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(scts_pkg::CMD_FIND, 0, 0, 0);
      send(scts_pkg::CMD_SORT, 0, 0, 0);
      send(scts_pkg::CMD_APPEND, 32767, -32768, 32767);
      send(scts_pkg::CMD_APPEND, -32768, 32767, -32768);
      send(scts_pkg::CMD_APPEND, 5, 5, 5);
      send(scts_pkg::CMD_APPEND, 5, 5, 5);
      send(scts_pkg::CMD_APPEND, 32768, 0, 0);
      send(scts_pkg::CMD_APPEND, 0, -32769, 0);
      send(scts_pkg::CMD_APPEND, 0, 0, 32'h8000_0000);
      send(scts_pkg::CMD_FIND, 5, 5, 5);
      send(scts_pkg::CMD_FIND, 32'h7fff_ffff, 0, 0);
      send(scts_pkg::CMD_SPARE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send(scts_pkg::CMD_SORT, 0, 0, 0);
      send(scts_pkg::CMD_FIND, 5, 5, 5);
      send(scts_pkg::CMD_FIND, 32767, -32768, 32767);
      send(scts_pkg::CMD_FIND, -32768, 32767, -32768);
      send(scts_pkg::CMD_FIND, 4, 5, 5);
      send(scts_pkg::CMD_FIND, 0, 0, 32'hffff_8000);
      drain();
      for (int i = 0; i < 16; i++) begin
         pool_x[i] = $signed($urandom_range(15)) - 8;
         pool_y[i] = $signed($urandom_range(15)) - 8;
         pool_z[i] = $signed($urandom_range(15)) - 8;
      end
      for (int n = 0; n < 820; n++) begin
         calm = (n >= 300 && n < 420);
         c = $urandom_range(99);
         if (c < 40)
            begin
               if ($urandom_range(9) == 0)
                  send(scts_pkg::CMD_APPEND, rnd_coord(1), rnd_coord(1), rnd_coord(0));
               else begin
                  int p;
                  p = $urandom_range(15);
                  send(scts_pkg::CMD_APPEND, pool_x[p], pool_y[p], pool_z[p]);
               end
            end
         else if (c < 45) send(scts_pkg::CMD_SORT, $urandom, $urandom, $urandom);
         else if (c < 47) send(scts_pkg::CMD_SPARE, $urandom, $urandom, $urandom);
         else if (c < 55) send(scts_pkg::CMD_FIND, rnd_coord(1), rnd_coord(0), rnd_coord(1));
         else begin
            int p;
            p = $urandom_range(15);
            send(scts_pkg::CMD_FIND, pool_x[p], pool_y[p], pool_z[p]);
         end
         if (n == 500) drain();
      end
      send(scts_pkg::CMD_APPEND, 1, 1, 1);
      send(scts_pkg::CMD_APPEND, 1, 1, 40000);
      send(scts_pkg::CMD_SORT, 0, 0, 0);
      for (int n = 0; n < 10; n++) send(scts_pkg::CMD_FIND, rnd_coord(0), 0, 0);
      send(scts_pkg::CMD_FIND, sb.kx[sb.key_count-1], sb.ky[sb.key_count-1],
           sb.kz[sb.key_count-1]);
      send(scts_pkg::CMD_FIND, sb.kx[0], sb.ky[0], sb.kz[0]);
      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d transfers, %0d keys held, %0d finds hit", transfers,
               sb.key_count, sb.found_hits);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("sorted_coordinate_table_search_core: match");
      else
         $display("sorted_coordinate_table_search_core: mismatch");
      $finish;
   end
endmodule
